/* src/three_level_fifo_cache_lookup_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the three-level FIFO cache lookup
// Immediate-next and same-cycle implication checks under synchronous reset.
// -----------------------------------------------------------------------------
`ifndef THREE_LEVEL_FIFO_CACHE_LOOKUP_ASSERT_SVH
`define THREE_LEVEL_FIFO_CACHE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define FCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/fcl_pkg.sv */
// -----------------------------------------------------------------------------
// fcl_pkg
// Shared types and constants of the three-level FIFO cache lookup.
// -----------------------------------------------------------------------------
package fcl_pkg;

    localparam int L1_DEPTH_DEF  = 32;
    localparam int L2_DEPTH_DEF  = 128;
    localparam int L3_DEPTH_DEF  = 512;
    localparam int TAG_BITS_DEF  = 32;

    localparam int BLOCK_TAG_W   = 32;
    localparam int HIT_W         = 2;
    localparam int COUNT_W       = 32;

    typedef enum logic [HIT_W-1:0] {
        HIT_L1   = 2'd0,
        HIT_L2   = 2'd1,
        HIT_L3   = 2'd2,
        HIT_MISS = 2'd3
    } t_hit;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic lookup;
        logic insert;
    } t_cell_ctrl;

endpackage

/* src/fcl_if.sv */
// -----------------------------------------------------------------------------
// fcl_in_if / fcl_out_if
// Valid/ready channels carrying lookup requests and lookup results.
// -----------------------------------------------------------------------------
interface fcl_in_if import fcl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BLOCK_TAG_W-1:0] block_tag;

    modport source (output valid, output block_tag, input ready);
    modport sink   (input valid, input block_tag, output ready);
endinterface

interface fcl_out_if import fcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [HIT_W-1:0]   hit_level;
    logic               ram_access;
    logic [COUNT_W-1:0] ram_access_total;

    modport source (output valid, output hit_level, output ram_access,
                    output ram_access_total, input ready);
    modport sink   (input valid, input hit_level, input ram_access,
                    input ram_access_total, output ready);
endinterface

/* src/three_level_fifo_cache_lookup.sv */
// -----------------------------------------------------------------------------
// three_level_fifo_cache_lookup
// Looks up block tags in three FIFO-replaced fully associative levels.
// -----------------------------------------------------------------------------
// Usage:
//   i_in  (sink)  : one block_tag per transfer.
//   o_out (source): one result per request: hit_level (0 L1, 1 L2, 2 L3,
//                   3 miss), ram_access and the saturating ram_access_total.
// Each level is a chain of tag cells; a transfer in compares the tag in every
// cell at once and registers the match bits. The update state then reduces the
// matches, shifts the tag into each level above the first one that hit (into
// all three on a miss) and loads the result register. A request passes through
// the compare stage and then the insert stage, and no new request is taken
// until its insert stage is done.
// The result register lets a new request be taken while the previous result
// waits; if the receiver stalls, the insert step holds until the result
// register frees, and no further request is taken meanwhile.
// Reset: all levels empty, RAM access count zero, no result pending. No
// clearing pass is needed; requests are taken in the first cycle after reset.
// -----------------------------------------------------------------------------
`include "three_level_fifo_cache_lookup_assert.svh"

module three_level_fifo_cache_lookup import fcl_pkg::*; #(
    parameter int FIRST_LEVEL_DEPTH  = L1_DEPTH_DEF,
    parameter int SECOND_LEVEL_DEPTH = L2_DEPTH_DEF,
    parameter int THIRD_LEVEL_DEPTH  = L3_DEPTH_DEF,
    parameter int TAG_BITS           = TAG_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcl_in_if.sink     i_in,
    fcl_out_if.source  o_out
);

    t_state               r_state;
    t_state               n_state;
    logic [TAG_BITS-1:0]  w_tag;
    logic [TAG_BITS-1:0]  r_tag;
    logic                 w_accept;
    logic                 w_commit;
    logic                 w_out_free;
    logic                 w_hit1;
    logic                 w_hit2;
    logic                 w_hit3;
    logic                 w_miss;
    t_hit                 w_hit;
    t_cell_ctrl           w_ctrl1;
    t_cell_ctrl           w_ctrl2;
    t_cell_ctrl           w_ctrl3;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic                 r_out_valid;
    t_hit                 r_hit;
    logic                 r_ram;
    logic [COUNT_W-1:0]   r_total;

    if (TAG_BITS <= BLOCK_TAG_W) begin : g_tag_trunc
        assign w_tag = i_in.block_tag[TAG_BITS-1:0];
    end else begin : g_tag_ext
        assign w_tag = {{(TAG_BITS - BLOCK_TAG_W){1'b0}}, i_in.block_tag};
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            S_IDLE:   i_in.ready = 1'b1;
            S_UPDATE: w_commit   = w_out_free;
            default: begin
                i_in.ready = 1'b0;
                w_commit   = 1'b0;
            end
        endcase
    end

    assign w_miss = !w_hit1 && !w_hit2 && !w_hit3;

    always_comb begin
        if (w_hit1) begin
            w_hit = HIT_L1;
        end else if (w_hit2) begin
            w_hit = HIT_L2;
        end else if (w_hit3) begin
            w_hit = HIT_L3;
        end else begin
            w_hit = HIT_MISS;
        end
    end

    assign w_ctrl1 = '{lookup: w_accept, insert: w_commit && !w_hit1};
    assign w_ctrl2 = '{lookup: w_accept, insert: w_commit && !w_hit1 && !w_hit2};
    assign w_ctrl3 = '{lookup: w_accept, insert: w_commit && w_miss};

    always_comb begin
        n_count = r_count;
        if (w_commit && w_miss && (r_count != '1)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag <= w_tag;
        end
        if (w_commit) begin
            r_hit   <= w_hit;
            r_ram   <= w_miss;
            r_total <= n_count;
        end
    end

    fcl_level #(.DEPTH(FIRST_LEVEL_DEPTH), .TAG_BITS(TAG_BITS)) u_level1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl1),
        .i_lookup_tag (w_tag),
        .i_insert_tag (r_tag),
        .o_hit        (w_hit1)
    );

    fcl_level #(.DEPTH(SECOND_LEVEL_DEPTH), .TAG_BITS(TAG_BITS)) u_level2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl2),
        .i_lookup_tag (w_tag),
        .i_insert_tag (r_tag),
        .o_hit        (w_hit2)
    );

    fcl_level #(.DEPTH(THIRD_LEVEL_DEPTH), .TAG_BITS(TAG_BITS)) u_level3 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl3),
        .i_lookup_tag (w_tag),
        .i_insert_tag (r_tag),
        .o_hit        (w_hit3)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.hit_level        = r_hit;
    assign o_out.ram_access       = r_ram;
    assign o_out.ram_access_total = r_total;

    `FCL_ASSERT_NEXT(a_ram_flag_matches_level, i_clk, i_rst_n, w_commit,
        o_out.ram_access == (o_out.hit_level == HIT_MISS), "ram flag disagrees with level")
    `FCL_ASSERT_NEXT(a_no_overlap, i_clk, i_rst_n, w_accept,
        !i_in.ready, "request taken while previous one in progress")
    `FCL_ASSERT_NEXT(a_count_holds_on_hit, i_clk, i_rst_n, w_commit && !w_miss,
        $stable(r_count), "RAM access count moved on a cache hit")
    `FCL_ASSERT_NOW(a_commit_needs_slot, i_clk, i_rst_n, w_commit,
        !r_out_valid || o_out.ready, "result overwritten before transfer")

endmodule

/* src/fcl_cell.sv */
// -----------------------------------------------------------------------------
// fcl_cell
// One tag entry of a level: shifts toward the older end on insert and
// registers its compare against the lookup tag.
// -----------------------------------------------------------------------------
module fcl_cell import fcl_pkg::*; #(
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int FILL_W   = 6,
    parameter int INDEX    = 0
) (
    input  logic                i_clk,
    input  t_cell_ctrl          i_ctrl,
    input  logic [FILL_W-1:0]   i_fill,
    input  logic [TAG_BITS-1:0] i_lookup_tag,
    input  logic [TAG_BITS-1:0] i_shift_tag,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_match
);

    logic [TAG_BITS-1:0] r_tag;
    logic                r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            r_tag <= i_shift_tag;
        end
        if (i_ctrl.lookup) begin
            r_match <= (i_fill > FILL_W'(INDEX)) && (r_tag == i_lookup_tag);
        end
    end

    assign o_tag   = r_tag;
    assign o_match = r_match;

endmodule

/* src/fcl_level.sv */
// -----------------------------------------------------------------------------
// fcl_level
// One fully associative FIFO level: a chain of cells, newest at cell zero,
// oldest at the far end, plus the fill count.
// -----------------------------------------------------------------------------
module fcl_level import fcl_pkg::*; #(
    parameter int DEPTH    = L1_DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    input  logic [TAG_BITS-1:0] i_lookup_tag,
    input  logic [TAG_BITS-1:0] i_insert_tag,
    output logic                o_hit
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [TAG_BITS-1:0] w_tag [DEPTH];
    logic [DEPTH-1:0]    w_match;

    always_comb begin
        n_fill = r_fill;
        if (i_ctrl.insert && (r_fill != FILL_W'(DEPTH))) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [TAG_BITS-1:0] w_shift_in;
        if (g == 0) begin : g_head
            assign w_shift_in = i_insert_tag;
        end else begin : g_body
            assign w_shift_in = w_tag[g-1];
        end
        fcl_cell #(
            .TAG_BITS (TAG_BITS),
            .FILL_W   (FILL_W),
            .INDEX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_fill       (r_fill),
            .i_lookup_tag (i_lookup_tag),
            .i_shift_tag  (w_shift_in),
            .o_tag        (w_tag[g]),
            .o_match      (w_match[g])
        );
    end

    assign o_hit = |w_match;

endmodule

/* bench/tb_three_level_fifo_cache_lookup.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_three_level_fifo_cache_lookup
// Self-checking bench for the three-level FIFO cache lookup. A local model of
// the three FIFO-replaced levels and the RAM access counter predicts the
// result of each accepted tag. Every returned result is checked field by
// field. Stimulus mixes fresh tags with tags reused at short, medium and long
// distances so that L1, L2 and L3 hits and misses all occur. Both channels
// stall at random, and the run includes a long receiver hold-off and a full
// drain.
// -----------------------------------------------------------------------------
module tb_three_level_fifo_cache_lookup;
    import fcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HISTORY_DEPTH  = 700;
    localparam int MAX_DEPTH      = L3_DEPTH_DEF;

    typedef struct packed {
        t_hit               hit_level;
        logic               ram_access;
        logic [COUNT_W-1:0] ram_access_total;
    } t_lookup_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcl_in_if  lookup_if ();
    fcl_out_if result_if ();

    three_level_fifo_cache_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (lookup_if),
        .o_out   (result_if)
    );

    always #5 i_clk = ~i_clk;

    // cache model state
    logic [BLOCK_TAG_W-1:0] level_tags   [3][MAX_DEPTH];
    int                     level_fill   [3];
    int                     level_oldest [3];
    logic [COUNT_W-1:0]     ram_total;

    t_lookup_result         pending_results[$];
    logic [BLOCK_TAG_W-1:0] sent_tags[$];

    int  error_count;
    int  lookups_sent;
    int  results_checked;
    int  hit_count [4];
    int  idle_cycles;
    bit  src_idle_en;
    bit  sink_stall_en;
    int  sink_hold_req;
    int  sink_hold_left;

    function automatic int level_depth(input int lvl);
        case (lvl)
            0:       return L1_DEPTH_DEF;
            1:       return L2_DEPTH_DEF;
            default: return L3_DEPTH_DEF;
        endcase
    endfunction

    function automatic bit level_holds(input int lvl, input logic [BLOCK_TAG_W-1:0] tag);
        int slot;
        for (int i = 0; i < level_fill[lvl]; i++) begin
            slot = (level_oldest[lvl] + i) % level_depth(lvl);
            if (level_tags[lvl][slot] == tag)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void level_insert(input int lvl, input logic [BLOCK_TAG_W-1:0] tag);
        int depth;
        depth = level_depth(lvl);
        if (level_fill[lvl] >= depth) begin
            level_tags[lvl][level_oldest[lvl]] = tag;
            level_oldest[lvl] = (level_oldest[lvl] + 1) % depth;
        end else begin
            level_tags[lvl][(level_oldest[lvl] + level_fill[lvl]) % depth] = tag;
            level_fill[lvl]++;
        end
    endfunction

    function automatic t_lookup_result predict_lookup(input logic [BLOCK_TAG_W-1:0] tag);
        t_lookup_result res;
        res.ram_access = 1'b0;
        if (level_holds(0, tag)) begin
            res.hit_level = HIT_L1;
        end else if (level_holds(1, tag)) begin
            res.hit_level = HIT_L2;
            level_insert(0, tag);
        end else if (level_holds(2, tag)) begin
            res.hit_level = HIT_L3;
            level_insert(0, tag);
            level_insert(1, tag);
        end else begin
            res.hit_level  = HIT_MISS;
            res.ram_access = 1'b1;
            if (ram_total != '1)
                ram_total++;
            level_insert(0, tag);
            level_insert(1, tag);
            level_insert(2, tag);
        end
        res.ram_access_total = ram_total;
        return res;
    endfunction

    // predict on input transfer, check on output transfer, watch for hangs
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n) begin
            if (lookup_if.valid && lookup_if.ready)
                pending_results = {pending_results, predict_lookup(lookup_if.block_tag)};
            if (result_if.valid && result_if.ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    $error("unexpected result: hit_level %0d ram_access %0d total %0d",
                           result_if.hit_level, result_if.ram_access,
                           result_if.ram_access_total);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    hit_count[want.hit_level]++;
                    if (result_if.hit_level !== want.hit_level) begin
                        error_count++;
                        $error("hit_level: expected %0d, got %0d",
                               want.hit_level, result_if.hit_level);
                    end
                    if (result_if.ram_access !== want.ram_access) begin
                        error_count++;
                        $error("ram_access: expected %0d, got %0d",
                               want.ram_access, result_if.ram_access);
                    end
                    if (result_if.ram_access_total !== want.ram_access_total) begin
                        error_count++;
                        $error("ram_access_total: expected %0d, got %0d",
                               want.ram_access_total, result_if.ram_access_total);
                    end
                end
            end
            if ((lookup_if.valid && lookup_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts and requested long hold-offs
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            result_if.ready <= 1'b0;
        end else if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req - 1;
            sink_hold_req  = 0;
            result_if.ready <= 1'b0;
        end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
            sink_hold_left = $urandom_range(0, 14);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    task automatic send_lookup(input logic [BLOCK_TAG_W-1:0] tag);
        lookup_if.valid     <= 1'b1;
        lookup_if.block_tag <= tag;
        sent_tags = {sent_tags, tag};
        if (sent_tags.size() > HISTORY_DEPTH)
            sent_tags.delete(0);
        lookups_sent++;
        @(posedge i_clk);
        while (!lookup_if.ready)
            @(posedge i_clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            lookup_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        lookup_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // fresh tags, or reuse at distances that land in L1, L2 or L3
    function automatic logic [BLOCK_TAG_W-1:0] pick_tag();
        int n;
        int pick;
        int lo;
        int hi;
        n    = sent_tags.size();
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 40)
            return $urandom;
        if (pick < 65) begin
            lo = 1;
            hi = 16;
        end else if (pick < 80) begin
            lo = 40;
            hi = 150;
        end else begin
            lo = 200;
            hi = 600;
        end
        if (hi > n)
            hi = n;
        if (lo > hi)
            lo = hi;
        return sent_tags[n - $urandom_range(lo, hi)];
    endfunction

    task automatic test_extremes();
        logic [BLOCK_TAG_W-1:0] corner_tags[$];
        corner_tags = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001,
                       32'h8000_0000, 32'hAAAA_AAAA, 32'h0000_0000, 32'h7FFF_FFFF};
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        foreach (corner_tags[i])
            send_lookup(corner_tags[i]);
        wait_drained();
    endtask

    task automatic test_long_stall();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        sink_hold_req = 300;
        repeat (40)
            send_lookup(pick_tag());
        wait_drained();
    endtask

    task automatic test_drain_pause();
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        repeat (30)
            send_lookup(pick_tag());
        wait_drained();
        repeat (30)
            send_lookup(pick_tag());
        wait_drained();
    endtask

    task automatic test_random_reuse();
        for (int phase = 0; phase < 7; phase++) begin
            src_idle_en   = (phase % 3) != 2;
            sink_stall_en = (phase % 3) != 1;
            repeat (180)
                send_lookup(pick_tag());
        end
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        repeat (120)
            send_lookup(pick_tag());
        wait_drained();
    endtask

    initial begin
        error_count     = 0;
        lookups_sent    = 0;
        results_checked = 0;
        idle_cycles     = 0;
        sink_hold_req   = 0;
        sink_hold_left  = 0;
        src_idle_en     = 1'b0;
        sink_stall_en   = 1'b0;
        hit_count       = '{0, 0, 0, 0};
        ram_total       = '0;
        level_fill      = '{0, 0, 0};
        level_oldest    = '{0, 0, 0};
        i_rst_n             <= 1'b0;
        lookup_if.valid     <= 1'b0;
        lookup_if.block_tag <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_long_stall();
        test_drain_pause();
        test_random_reuse();

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results of %0d lookups: L1 %0d, L2 %0d, L3 %0d, RAM %0d",
                 results_checked, lookups_sent, hit_count[HIT_L1], hit_count[HIT_L2],
                 hit_count[HIT_L3], hit_count[HIT_MISS]);
        $display("Stalls on both sides, a 300-cycle receiver hold-off and drains included");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* three_level_fifo_cache_lookup.f */
+incdir+src
src/fcl_pkg.sv
src/fcl_if.sv
src/fcl_cell.sv
src/fcl_level.sv
src/three_level_fifo_cache_lookup.sv
bench/tb_three_level_fifo_cache_lookup.sv
